>>> sv/brsi_pkg.sv
// ----------------------------------------------------------------------------
// Battery relay safety interlock package
// Shared types, command codes, register map and reset values.
// ----------------------------------------------------------------------------
package brsi_pkg;

   // Input item command codes
   localparam logic [1:0] CMD_PACK_STATUS = 2'd0;
   localparam logic [1:0] CMD_ERROR       = 2'd1;
   localparam logic [1:0] CMD_CONTACTOR   = 2'd2;
   localparam logic [1:0] CMD_TICK        = 2'd3;

   // Sequencer phase codes
   localparam logic [1:0] PHASE_IDLE         = 2'd0;
   localparam logic [1:0] PHASE_WAIT_CONTACT = 2'd1;
   localparam logic [1:0] PHASE_CLOSE_DELAY  = 2'd2;
   localparam logic [1:0] PHASE_CHARGE_DELAY = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_STARTUP_WINDOW = 2'd0;
   localparam logic [1:0] REG_CLOSE_DELAY    = 2'd1;
   localparam logic [1:0] REG_CHARGE_DELAY   = 2'd2;
   localparam logic [1:0] REG_FLASH_PERIOD   = 2'd3;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned TIMER_W    = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   // Register reset values
   localparam logic [3:0]         STARTUP_WINDOW_RST = 4'd5;
   localparam logic [TIMER_W-1:0] CLOSE_DELAY_RST    = 16'd9000;
   localparam logic [TIMER_W-1:0] CHARGE_DELAY_RST   = 16'd1000;
   localparam logic [TIMER_W-1:0] FLASH_PERIOD_RST   = 16'd500;

   // Pending event bits
   localparam int unsigned EV_DISCHARGE = 0;
   localparam int unsigned EV_CHARGE    = 1;
   localparam int unsigned EV_CLOSED    = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic       discharge_status;
      logic       charge_status;
      logic       error_present;
      logic       contactor_level;
   } req_payload_type;

   typedef struct packed {
      logic discharge_enable;
      logic charge_enable;
      logic fault;
      logic fault_indicator;
      logic tripped;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0]         startup_window;
      logic [TIMER_W-1:0] close_delay_ticks;
      logic [TIMER_W-1:0] charge_delay_ticks;
      logic [TIMER_W-1:0] flash_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic               last_discharge;
      logic               last_charge;
      logic [3:0]         report_count;
      logic               fault;
      logic               trip;
      logic [2:0]         pending;
      logic [1:0]         phase;
      logic [1:0]         seq_requests;
      logic [TIMER_W-1:0] delay_timer;
      logic [TIMER_W-1:0] flash_timer;
      logic               indicator;
      logic [1:0]         relays;
      logic               contactor;
   } state_type;

endpackage

>>> sv/brsi_stream_if.sv
// ----------------------------------------------------------------------------
// Battery relay safety interlock stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface brsi_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/brsi_step.sv
// ----------------------------------------------------------------------------
// Battery relay safety interlock step logic
// Next state for one input item: event handling, trip, timers and sequencer.
// ----------------------------------------------------------------------------
module brsi_step import brsi_pkg::*; (
   input  cfg_type         cfg,
   input  state_type       cur,
   input  req_payload_type item,
   output state_type       nxt
);

   logic               drop;
   logic               early;
   logic [TIMER_W-1:0] period;

   assign period = (cfg.flash_period_ticks == '0) ? TIMER_W'(1) : cfg.flash_period_ticks;

   always_comb begin
      nxt   = cur;
      drop  = 1'b0;
      early = 1'b0;

      // Apply the event
      unique case (item.cmd)
         CMD_PACK_STATUS: begin
            drop  = (cur.last_discharge && !item.discharge_status) ||
                    (cur.last_charge && !item.charge_status);
            early = cur.report_count < cfg.startup_window;
            if (!cur.last_discharge && item.discharge_status && early) begin
               nxt.pending[EV_DISCHARGE] = 1'b1;
            end
            if (!cur.last_charge && item.charge_status && early) begin
               nxt.pending[EV_CHARGE] = 1'b1;
            end
            nxt.last_discharge = item.discharge_status;
            nxt.last_charge    = item.charge_status;
            if (!early && (!item.discharge_status || !item.charge_status)) begin
               nxt.fault = 1'b1;
            end
            if (early) begin
               nxt.report_count = cur.report_count + 4'd1;
            end
         end
         CMD_ERROR: begin
            if (item.error_present) begin
               nxt.fault = 1'b1;
            end
         end
         CMD_CONTACTOR: begin
            if (!cur.contactor && item.contactor_level) begin
               nxt.pending[EV_CLOSED] = 1'b1;
            end
            drop          = cur.contactor && !item.contactor_level;
            nxt.contactor = item.contactor_level;
         end
         CMD_TICK: begin
            if (cur.flash_timer != TIMER_MAX) begin
               nxt.flash_timer = cur.flash_timer + TIMER_W'(1);
            end
            if (nxt.flash_timer >= period) begin
               nxt.flash_timer = '0;
               nxt.indicator   = cur.fault ? !cur.indicator : 1'b0;
            end
            if ((cur.phase == PHASE_CLOSE_DELAY || cur.phase == PHASE_CHARGE_DELAY) &&
                cur.delay_timer != TIMER_MAX) begin
               nxt.delay_timer = cur.delay_timer + TIMER_W'(1);
            end
         end
         default: begin
         end
      endcase

      // Trip: open both relays and stop sequencing
      if (drop) begin
         nxt.trip         = 1'b1;
         nxt.fault        = 1'b1;
         nxt.relays       = '0;
         nxt.phase        = PHASE_IDLE;
         nxt.seq_requests = '0;
         nxt.delay_timer  = '0;
      end

      // One pass through the sequencer
      if (!nxt.trip) begin
         if (nxt.phase == PHASE_IDLE && nxt.pending[1:0] != 2'b00) begin
            nxt.seq_requests = nxt.pending[1:0];
            nxt.pending      = {nxt.pending[EV_CLOSED], 2'b00};
            nxt.phase        = PHASE_WAIT_CONTACT;
         end
         if (nxt.phase == PHASE_WAIT_CONTACT) begin
            if (nxt.contactor || nxt.pending[EV_CLOSED]) begin
               nxt.pending[EV_CLOSED] = 1'b0;
               nxt.delay_timer        = '0;
               nxt.phase              = PHASE_CLOSE_DELAY;
            end
         end
         if (nxt.phase == PHASE_CLOSE_DELAY && nxt.delay_timer >= cfg.close_delay_ticks) begin
            if (nxt.seq_requests[0]) begin
               nxt.relays[0] = 1'b1;
            end
            nxt.delay_timer = '0;
            nxt.phase       = PHASE_CHARGE_DELAY;
         end
         if (nxt.phase == PHASE_CHARGE_DELAY &&
             nxt.delay_timer >= cfg.charge_delay_ticks) begin
            if (nxt.seq_requests[1]) begin
               nxt.relays[1] = 1'b1;
            end
            nxt.delay_timer  = '0;
            nxt.seq_requests = '0;
            nxt.phase        = PHASE_IDLE;
         end
      end
   end

endmodule

>>> sv/battery_relay_safety_interlock_unit.sv
// ----------------------------------------------------------------------------
// Battery relay safety interlock unit
// Relay sequencing and trip protection driven by pack events and ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one event per transfer: a pack status report, an error
//   report, a contactor sense level or a 1 ms tick (field cmd selects).
//   rsp_ch returns exactly one result per event: both relay drives, the
//   latched fault, the flashing fault lamp and the trip flag, all as they
//   stand after the event.
//   An accepted event's result is registered and valid in the next cycle.
//   Throughput is one event per cycle while the receiver keeps up; the state
//   update is a single pass of short logic from the state registers.
//   A one-entry result register decouples the sides: a new event is taken
//   while the result register is empty or being taken in the same cycle.
//   When the receiver stalls, the result holds and req_ch.ready drops.
//   The APB port (psel/penable/pwrite/paddr/pwdata) writes four registers at
//   byte addresses 0, 4, 8 and 12; write them only while no event is in
//   flight. pready is tied high, reads return the register value.
//   Synchronous reset clears the interlock state (relays open, no fault) and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module battery_relay_safety_interlock_unit import brsi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   brsi_stream_if.sink           req_ch,
   brsi_stream_if.source         rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   state_type       state_ff;
   state_type       state_in;
   req_payload_type item;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accept;
   logic            csr_write;
   logic [1:0]      csr_index;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_STARTUP_WINDOW: cfg_in.startup_window     = pwdata[3:0];
            REG_CLOSE_DELAY:    cfg_in.close_delay_ticks  = pwdata[TIMER_W-1:0];
            REG_CHARGE_DELAY:   cfg_in.charge_delay_ticks = pwdata[TIMER_W-1:0];
            REG_FLASH_PERIOD:   cfg_in.flash_period_ticks = pwdata[TIMER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_STARTUP_WINDOW: prdata = CSR_DATA_W'(cfg_ff.startup_window);
         REG_CLOSE_DELAY:    prdata = CSR_DATA_W'(cfg_ff.close_delay_ticks);
         REG_CHARGE_DELAY:   prdata = CSR_DATA_W'(cfg_ff.charge_delay_ticks);
         REG_FLASH_PERIOD:   prdata = CSR_DATA_W'(cfg_ff.flash_period_ticks);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_window     <= STARTUP_WINDOW_RST;
         cfg_ff.close_delay_ticks  <= CLOSE_DELAY_RST;
         cfg_ff.charge_delay_ticks <= CHARGE_DELAY_RST;
         cfg_ff.flash_period_ticks <= FLASH_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept a new event while the result register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign item         = req_ch.payload;

   brsi_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item),
      .nxt  (state_in)
   );

   // Advance state on each accepted event
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.discharge_enable = state_in.relays[0];
         rsp_data_in.charge_enable    = state_in.relays[1];
         rsp_data_in.fault            = state_in.fault;
         rsp_data_in.fault_indicator  = state_in.indicator;
         rsp_data_in.tripped          = state_in.trip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // Checks
   a_trip_opens_relays: assert property (@(posedge clock) disable iff (reset)
      state_ff.trip |-> (state_ff.relays == 2'b00 && state_ff.fault))
      else $error("relay closed or fault clear after trip");

   a_trip_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.trip |=> state_ff.trip)
      else $error("trip latch released");

   a_active_has_request: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != PHASE_IDLE |-> state_ff.seq_requests != 2'b00)
      else $error("sequencer active without a request");

   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PHASE_IDLE |-> state_ff.delay_timer == '0)
      else $error("delay timer running while sequencer idle");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff && rsp_data_ff.tripped == state_ff.trip &&
                  rsp_data_ff.fault == state_ff.fault))
      else $error("result does not match updated state");

endmodule
